FILE: hdl/ffa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit slot allocator package
// Transfer payload types, field widths, mode codes and the control and status
// groups exchanged between the sequencer and the slot scanner.
// ----------------------------------------------------------------------------
package ffa_pkg;

   // Field widths of the request and response transfers.
   localparam int OWNER_W = 4;
   localparam int LEN_W   = 3;
   localparam int BANK_OW = 2;
   localparam int SLOT_OW = 4;

   // Request modes.
   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [OWNER_W-1:0] owner_id;
      logic [LEN_W-1:0]   run_length;
   } req_type;

   typedef struct packed {
      logic               ok;
      logic [BANK_OW-1:0] bank;
      logic [SLOT_OW-1:0] first_slot;
      logic [SLOT_OW-1:0] last_slot;
   } rsp_type;

   // Commands from the sequencer to the slot scanner.
   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctrl_type;

   // Status from the slot scanner for the current step.
   typedef struct packed {
      logic hit;
      logic wrap;
   } scan_stat_type;

endpackage

FILE: hdl/first_fit_contiguous_slot_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit contiguous slot allocator
// Grants each owner the lowest run of adjacent free slots in the lowest bank
// that has room, records the run per owner and frees it on release.
// ----------------------------------------------------------------------------
// A refused request goes straight to its response; a release first reads the
// owner's run from the run table and clears it, and an allocate scans at most
// BANKS * SLOTS_PER_BANK slots (one slot per cycle through the slot scanner).
// One request is in flight at a time; the next is taken once the response is
// loaded into the output register.
// Reset clears occupancy and owner valid bits at once; no clearing pass.
module first_fit_contiguous_slot_allocator_core #(
   parameter int BANKS          = 4,
   parameter int SLOTS_PER_BANK = 16,
   parameter int OWNERS         = 16,
   parameter int MAX_RUN        = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ffa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ffa_pkg::rsp_type rsp_data
);

   localparam int BANK_W  = (BANKS > 1) ? $clog2(BANKS) : 1;
   localparam int SLOT_W  = $clog2(SLOTS_PER_BANK);
   localparam int OWN_W   = $clog2(OWNERS);
   localparam int RUN_W   = BANK_W + 2 * SLOT_W;
   localparam int OEXT_W  = ffa_pkg::OWNER_W + OWN_W;
   localparam int FIRST_W = SLOT_W + ffa_pkg::LEN_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_RELEASE = 4'b0010,
      ST_SCAN    = 4'b0100,
      ST_DONE    = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   ffa_pkg::req_type      req_ff, req_in;
   ffa_pkg::rsp_type      res_ff, res_in;
   ffa_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BANK_W-1:0]     bank_ptr_ff, bank_ptr_in;
   logic [SLOTS_PER_BANK-1:0] occ_ff [BANKS];
   logic [SLOTS_PER_BANK-1:0] occ_in [BANKS];
   logic [OWNERS-1:0]     owner_valid_ff, owner_valid_in;

   logic                  accept;
   logic [OEXT_W-1:0]     in_owner_ext, hold_owner_ext;
   logic [OWN_W-1:0]      in_idx, hold_idx;
   logic                  in_range;
   logic [15:0]           in_len_ext;
   logic                  alloc_bad;

   logic                  ram_we, ram_re;
   logic [RUN_W-1:0]      ram_wdata, ram_rdata;
   logic [BANK_W-1:0]     rel_bank;
   logic [SLOT_W-1:0]     rel_first, rel_last;

   ffa_pkg::scan_ctrl_type scan_ctrl;
   ffa_pkg::scan_stat_type scan_stat;
   logic [SLOT_W-1:0]     scan_slot;
   logic [FIRST_W-1:0]    first_wide;
   logic [SLOT_W-1:0]     alloc_first;

   logic [BANK_W-1:0]     sel_bank;
   logic [SLOT_W-1:0]     mask_lo, mask_hi;
   logic [SLOTS_PER_BANK-1:0] run_mask;
   logic [BANK_W+ffa_pkg::BANK_OW-1:0] bank_ext;
   logic [SLOT_W+ffa_pkg::SLOT_OW-1:0] first_ext, last_ext;
   ffa_pkg::rsp_type      grant_rsp;

   // Request decode.
   assign accept         = req_valid && req_ready;
   assign req_ready      = (state_ff == ST_IDLE);
   assign in_owner_ext   = OEXT_W'(req_data.owner_id);
   assign in_idx         = in_owner_ext[OWN_W-1:0];
   assign in_range       = (in_owner_ext < OEXT_W'(OWNERS));
   assign hold_owner_ext = OEXT_W'(req_ff.owner_id);
   assign hold_idx       = hold_owner_ext[OWN_W-1:0];
   assign in_len_ext     = 16'(req_data.run_length);
   assign alloc_bad      = owner_valid_ff[in_idx] || (in_len_ext == 16'd0) ||
                           (in_len_ext > 16'(MAX_RUN)) ||
                           (in_len_ext > 16'(SLOTS_PER_BANK));

   // Owner run table: bank, first slot and last slot of each held run.
   ffa_ram #(
      .WIDTH (RUN_W),
      .DEPTH (OWNERS)
   ) u_run_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hold_idx),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (in_idx),
      .rd_data (ram_rdata)
   );

   assign rel_bank  = ram_rdata[RUN_W-1 -: BANK_W];
   assign rel_first = ram_rdata[2*SLOT_W-1 -: SLOT_W];
   assign rel_last  = ram_rdata[SLOT_W-1:0];

   // Shared slot scanner over the bank under the bank pointer.
   ffa_scan #(
      .SLOTS_PER_BANK (SLOTS_PER_BANK)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (scan_ctrl),
      .word       (occ_ff[bank_ptr_ff]),
      .run_length (req_ff.run_length),
      .stat       (scan_stat),
      .slot       (scan_slot)
   );

   // First slot of a found run ends at the current slot.
   assign first_wide  = FIRST_W'(scan_slot) + FIRST_W'(1) - FIRST_W'(req_ff.run_length);
   assign alloc_first = first_wide[SLOT_W-1:0];
   assign ram_wdata   = {bank_ptr_ff, alloc_first, scan_slot};

   // One run mask serves both the release clear and the allocate set.
   always_comb begin
      if (state_ff == ST_RELEASE) begin
         sel_bank = rel_bank;
         mask_lo  = rel_first;
         mask_hi  = rel_last;
      end else begin
         sel_bank = bank_ptr_ff;
         mask_lo  = alloc_first;
         mask_hi  = scan_slot;
      end
      for (int s = 0; s < SLOTS_PER_BANK; s++) begin
         run_mask[s] = (s >= int'(mask_lo)) && (s <= int'(mask_hi));
      end
   end

   // Granted response, masked to the output field widths.
   always_comb begin
      bank_ext             = (BANK_W + ffa_pkg::BANK_OW)'(sel_bank);
      first_ext            = (SLOT_W + ffa_pkg::SLOT_OW)'(mask_lo);
      last_ext             = (SLOT_W + ffa_pkg::SLOT_OW)'(mask_hi);
      grant_rsp.ok         = 1'b1;
      grant_rsp.bank       = bank_ext[ffa_pkg::BANK_OW-1:0];
      grant_rsp.first_slot = first_ext[ffa_pkg::SLOT_OW-1:0];
      grant_rsp.last_slot  = last_ext[ffa_pkg::SLOT_OW-1:0];
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      res_in         = res_ff;
      bank_ptr_in    = bank_ptr_ff;
      occ_in         = occ_ff;
      owner_valid_in = owner_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      scan_ctrl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               ram_re = 1'b1;
               res_in = '0;
               priority if (!in_range) begin
                  state_in = ST_DONE;
               end else if (req_data.mode == ffa_pkg::MODE_RELEASE) begin
                  state_in = owner_valid_ff[in_idx] ? ST_RELEASE : ST_DONE;
               end else if (alloc_bad) begin
                  state_in = ST_DONE;
               end else begin
                  bank_ptr_in     = '0;
                  scan_ctrl.clear = 1'b1;
                  state_in        = ST_SCAN;
               end
            end
         end
         ST_RELEASE: begin
            occ_in[rel_bank]         = occ_ff[rel_bank] & ~run_mask;
            owner_valid_in[hold_idx] = 1'b0;
            res_in                   = grant_rsp;
            state_in                 = ST_DONE;
         end
         ST_SCAN: begin
            scan_ctrl.step = 1'b1;
            if (scan_stat.hit) begin
               occ_in[bank_ptr_ff]      = occ_ff[bank_ptr_ff] | run_mask;
               owner_valid_in[hold_idx] = 1'b1;
               ram_we                   = 1'b1;
               res_in                   = grant_rsp;
               state_in                 = ST_DONE;
            end else if (scan_stat.wrap) begin
               if (bank_ptr_ff == BANK_W'(BANKS - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  bank_ptr_in = bank_ptr_ff + BANK_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         occ_ff         <= '{default: '0};
         owner_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         occ_ff         <= occ_in;
         owner_valid_ff <= owner_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      bank_ptr_ff <= bank_ptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A refused response carries zero in every other field.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |->
      (rsp_data.bank == '0 && rsp_data.first_slot == '0 && rsp_data.last_slot == '0))
      else $error("refused response with nonzero fields");

   // The scanner only steps while a scan is under way.
   a_scan_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) |-> !scan_ctrl.step)
      else $error("scanner stepped outside a scan");

   // Every scan starts in the lowest bank.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && $past(state_ff) == ST_IDLE) |-> (bank_ptr_ff == '0))
      else $error("scan did not start at bank zero");

   // A grant leaves the owner marked as holding a run.
   a_grant_owner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_stat.hit) |=> owner_valid_ff[hold_idx])
      else $error("granted owner not marked valid");

endmodule

FILE: hdl/ffa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ffa_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot scanner
// Walks the slots of one bank word, one slot per step, counting the length of
// the current free run and flagging when it reaches the requested length.
// ----------------------------------------------------------------------------
module ffa_scan #(
   parameter int SLOTS_PER_BANK = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ffa_pkg::scan_ctrl_type            ctrl,
   input  logic [SLOTS_PER_BANK-1:0]         word,
   input  logic [ffa_pkg::LEN_W-1:0]         run_length,
   output ffa_pkg::scan_stat_type            stat,
   output logic [$clog2(SLOTS_PER_BANK)-1:0] slot
);

   localparam int SLOT_W = $clog2(SLOTS_PER_BANK);
   localparam int CNT_W  = $clog2(SLOTS_PER_BANK + 1);
   localparam int CMP_W  = CNT_W + ffa_pkg::LEN_W;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  count_ff, count_in, count_next;
   logic [CMP_W-1:0]  count_ext, len_ext;
   logic              at_last;

   // Free-run count including the slot under the pointer.
   always_comb begin
      count_next = word[slot_ff] ? '0 : count_ff + CNT_W'(1);
      count_ext  = CMP_W'(count_next);
      len_ext    = CMP_W'(run_length);
      at_last    = (slot_ff == SLOT_W'(SLOTS_PER_BANK - 1));
   end

   assign stat.hit  = ctrl.step && (count_ext == len_ext);
   assign stat.wrap = ctrl.step && at_last;
   assign slot      = slot_ff;

   // Pointer and count advance; the last slot of a bank wraps to a fresh run.
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         slot_in  = '0;
         count_in = '0;
      end else if (ctrl.step) begin
         if (at_last) begin
            slot_in  = '0;
            count_in = '0;
         end else begin
            slot_in  = slot_ff + SLOT_W'(1);
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
      end else begin
         slot_ff  <= slot_in;
         count_ff <= count_in;
      end
   end

endmodule
